/* sv/rdq_pkg.sv */
// Shared types and constants for the restricted deque.
// Depends on nothing; imported by rdq_cell and restricted_deque_unit.
package rdq_pkg;

   localparam int WORD_W = 32;
   localparam int FILL_W = 5;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_FULL   = 2'd2,
      ST_DENIED = 2'd3
   } status_type;

   localparam logic [1:0] MODE_NO_FRONT_PUSH = 2'd1;
   localparam logic [1:0] MODE_NO_REAR_POP   = 2'd2;

   typedef struct packed {
      logic shift_in;   // push front: every cell takes its left neighbour
      logic shift_out;  // pop front: every cell takes its right neighbour
      logic fill_rear;  // push rear: first empty cell takes the word
      logic drop_rear;  // pop rear: last held cell empties
   } cell_cmd_type;

endpackage

/* sv/rdq_cell.sv */
// One deque cell: a word and its valid bit, moved by neighbour hand-off.
// Depends on rdq_pkg.
module rdq_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  rdq_pkg::cell_cmd_type cmd,
   input  rdq_pkg::word_type    push_word,
   input  rdq_pkg::word_type    left_data,
   input  logic                 left_valid,
   input  rdq_pkg::word_type    right_data,
   input  logic                 right_valid,
   output rdq_pkg::word_type    data,
   output logic                 valid,
   output rdq_pkg::word_type    rear_tap
);
   import rdq_pkg::*;

   word_type data_ff, data_in;
   logic     valid_ff, valid_in;
   logic     is_rear;

   assign is_rear  = valid_ff && !right_valid;
   assign data     = data_ff;
   assign valid    = valid_ff;
   assign rear_tap = is_rear ? data_ff : '0;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (cmd.shift_in) begin
         data_in  = left_data;
         valid_in = left_valid;
      end else if (cmd.shift_out) begin
         data_in  = right_data;
         valid_in = right_valid;
      end else if (cmd.fill_rear && !valid_ff && left_valid) begin
         data_in  = push_word;
         valid_in = 1'b1;
      end else if (cmd.drop_rear && is_rear) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

/* sv/restricted_deque_unit.sv */
// Restricted deque top level: request decode, fill count and the chain of cells.
// Depends on rdq_pkg and rdq_cell.
//
// Usage: raise start with req_operation and req_push_value; the request is
// taken at the edge where start is high and busy is low. Operations are push
// front, push rear, pop front and pop rear. Exactly one result follows each
// request, in the cycle after it is taken, on the rsp_ ports for a single cycle marked by
// rsp_strobe: rsp_status, rsp_fill_level and, for a good pop, the removed
// word in rsp_popped_value (zero otherwise). The receiver cannot stall, so
// results must be taken as they appear.
// Throughput is one request per cycle outside reset. The entries
// sit in a row of DEPTH cells; a front push or pop shifts the whole row by
// one cell, a rear push or pop acts on the cell at the rear boundary, and the
// rear word is gathered over all cells.
// The restriction mode is written through csr_valid/csr_wdata, always ready.
// Reset empties the deque, clears the mode and holds busy high while asserted.
module restricted_deque_unit #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic signed [31:0] req_push_value,
   output logic        rsp_strobe,
   output logic signed [31:0] rsp_popped_value,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_fill_level,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_wdata
);
   import rdq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [1:0]   mode_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic         strobe_ff;
   word_type     popped_ff, popped_in;
   status_type   status_ff, status_in;
   logic [CNT_W-1:0] fill_ff;

   logic         accept;
   op_type       op;
   logic         denied;
   logic         is_full;
   logic         is_empty;
   cell_cmd_type cmd;

   word_type     cell_data [DEPTH];
   word_type     cell_tap  [DEPTH];
   logic [DEPTH-1:0] cell_valid;
   word_type     rear_word;

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign op        = op_type'(req_operation);
   assign is_full   = count_ff == CNT_W'(DEPTH);
   assign is_empty  = count_ff == '0;
   assign denied    = (op == OP_PUSH_FRONT && mode_ff == MODE_NO_FRONT_PUSH) ||
                      (op == OP_POP_REAR && mode_ff == MODE_NO_REAR_POP);

   always_comb begin
      rear_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rear_word = rear_word | cell_tap[i];
      end
   end

   always_comb begin
      cmd       = '0;
      count_in  = count_ff;
      popped_in = '0;
      status_in = ST_OK;
      if (denied) begin
         status_in = ST_DENIED;
      end else begin
         case (op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  cmd.shift_in  = accept && op == OP_PUSH_FRONT;
                  cmd.fill_rear = accept && op == OP_PUSH_REAR;
                  count_in      = count_ff + 1'b1;
               end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
               if (is_empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  cmd.shift_out = accept && op == OP_POP_FRONT;
                  cmd.drop_rear = accept && op == OP_POP_REAR;
                  popped_in     = (op == OP_POP_FRONT) ? cell_data[0] : rear_word;
                  count_in      = count_ff - 1'b1;
               end
            end
            default: status_in = ST_DENIED;
         endcase
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      word_type left_data, right_data;
      logic     left_valid, right_valid;
      if (i == 0) begin : g_head
         assign left_data  = req_push_value;
         assign left_valid = 1'b1;
      end else begin : g_mid
         assign left_data  = cell_data[i-1];
         assign left_valid = cell_valid[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_data  = '0;
         assign right_valid = 1'b0;
      end else begin : g_body
         assign right_data  = cell_data[i+1];
         assign right_valid = cell_valid[i+1];
      end
      rdq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .push_word   (req_push_value),
         .left_data   (left_data),
         .left_valid  (left_valid),
         .right_data  (right_data),
         .right_valid (right_valid),
         .data        (cell_data[i]),
         .valid       (cell_valid[i]),
         .rear_tap    (cell_tap[i])
      );
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         popped_ff <= popped_in;
         status_ff <= status_in;
         fill_ff   <= count_in;
      end
      if (reset) begin
         mode_ff   <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_wdata;
         end
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_status       = status_ff;
   assign rsp_fill_level   = FILL_W'(fill_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond depth");

   a_cells_match_count: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff))
      else $error("held cells disagree with fill count");

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("request without result");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_EMPTY |-> rsp_fill_level == '0)
      else $error("empty status with entries held");

   a_no_pop_no_word: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_OK |-> rsp_popped_value == '0)
      else $error("word reported on failed request");

endmodule
